// ----- rtl/core/cmfs_pkg.sv -----
// Shared constants and types for the cube map face selection block.
package cmfs_pkg;

  // Default widths of one direction component and of the coordinate fraction
  localparam int CMFS_COMPONENT_BITS = 16;
  localparam int CMFS_FRACTION_BITS  = 16;

  // Width of the face code
  localparam int CMFS_FACE_BITS = 3;

  // Face codes: sign and axis of the major component
  typedef enum logic [CMFS_FACE_BITS-1:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

endpackage

// ----- rtl/core/cubemap_face_select_top.sv -----
// Top level of the cube map face selection block: selection stage and divider cell chain.
//
// Input channel s_axis carries one direction vector per transaction (x, y, z as signed
// components). Output channel m_axis carries one result per input: the face code and the
// s and t coordinates as unsigned fractions with FRACTION_BITS fraction bits, truncated.
// A zero vector gives face -z with s = t = 0.
//
// One stage picks the major axis, one forms the numerators and divisor and the integer
// quotient bit, then a chain of FRACTION_BITS identical cells each retires one fraction
// bit of s and t. The last cell is the output register. Throughput is one transaction per
// cycle while m_axis_tready is high; every cell holds its own transaction and hands it on
// when the cell downstream can take it.
//
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When m_axis_tready is low, data collapses into empty cells upstream, so s_axis_tready
// stays high until every cell holds a transaction; nothing is dropped or repeated.
module cubemap_face_select_top
  import cmfs_pkg::*;
#(
  parameter int COMPONENT_BITS = CMFS_COMPONENT_BITS,
  parameter int FRACTION_BITS  = CMFS_FRACTION_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // dir_x, dir_y, dir_z from the lowest bit up, zero padded to whole bytes
  input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0]  s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // face_index, s_coord, t_coord from the lowest bit up, zero padded to whole bytes
  output logic [((CMFS_FACE_BITS+2*(FRACTION_BITS+1)+7)/8)*8-1:0] m_axis_tdata
);

  localparam int CB          = COMPONENT_BITS;
  localparam int FB          = FRACTION_BITS;
  localparam int OUT_BITS    = CMFS_FACE_BITS + 2 * (FB + 1);
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Cell chain links; link 0 comes from the selection stage, link FB is the output
  logic          cell_valid [FB+1];
  logic          cell_ready [FB+1];
  face_t         cell_face  [FB+1];
  logic [CB:0]   cell_den   [FB+1];
  logic [CB:0]   cell_rs    [FB+1];
  logic [CB:0]   cell_rt    [FB+1];
  logic [FB:0]   cell_qs    [FB+1];
  logic [FB:0]   cell_qt    [FB+1];

  logic          sel_qs, sel_qt;

  // Select the face and set up the division
  cmfs_select #(
    .COMPONENT_BITS(CB)
  ) u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .dir_x     (s_axis_tdata[CB-1:0]),
    .dir_y     (s_axis_tdata[2*CB-1:CB]),
    .dir_z     (s_axis_tdata[3*CB-1:2*CB]),
    .out_valid (cell_valid[0]),
    .out_ready (cell_ready[0]),
    .out_face  (cell_face[0]),
    .out_den   (cell_den[0]),
    .out_rs    (cell_rs[0]),
    .out_rt    (cell_rt[0]),
    .out_qs    (sel_qs),
    .out_qt    (sel_qt)
  );

  assign cell_qs[0] = (FB+1)'(sel_qs);
  assign cell_qt[0] = (FB+1)'(sel_qt);

  // Chain of division cells, one fraction bit each
  for (genvar i = 0; i < FB; i++) begin : g_cell
    cmfs_div_cell #(
      .COMPONENT_BITS(CB),
      .FRACTION_BITS (FB)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_valid[i]),
      .in_ready  (cell_ready[i]),
      .in_face   (cell_face[i]),
      .in_den    (cell_den[i]),
      .in_rs     (cell_rs[i]),
      .in_rt     (cell_rt[i]),
      .in_qs     (cell_qs[i]),
      .in_qt     (cell_qt[i]),
      .out_valid (cell_valid[i+1]),
      .out_ready (cell_ready[i+1]),
      .out_face  (cell_face[i+1]),
      .out_den   (cell_den[i+1]),
      .out_rs    (cell_rs[i+1]),
      .out_rt    (cell_rt[i+1]),
      .out_qs    (cell_qs[i+1]),
      .out_qt    (cell_qt[i+1])
    );
  end

  // Drive the output channel from the last cell
  assign cell_ready[FB]  = m_axis_tready;
  assign m_axis_tvalid   = cell_valid[FB];
  assign m_axis_tdata    = OUT_TDATA_W'({cell_qt[FB], cell_qs[FB], cell_face[FB]});

  // Input stalls only when the whole chain is full and the output is blocked
  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the cell chain has room");

  // The remainder entering the chain stays below the divisor
  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    cell_valid[0] |-> (cell_rs[0] < cell_den[0]) && (cell_rt[0] < cell_den[0]))
    else $error("division remainder out of range at chain entry");

  // Coordinates never exceed one
  a_coord_max : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (cell_qs[FB] <= {1'b1, {FB{1'b0}}}) &&
                      (cell_qt[FB] <= {1'b1, {FB{1'b0}}}))
    else $error("face coordinate above one");

  // A zero divisor never reaches the chain
  a_den_nonzero : assert property (@(posedge clk) disable iff (rst)
    cell_valid[0] |-> (cell_den[0] != '0))
    else $error("zero divisor entered the cell chain");

endmodule

// ----- rtl/core/cmfs_select.sv -----
// Face selection and divider setup: picks the major axis, forms numerators and divisor.
module cmfs_select
  import cmfs_pkg::*;
#(
  parameter int COMPONENT_BITS = CMFS_COMPONENT_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COMPONENT_BITS-1:0] dir_x,
  input  logic [COMPONENT_BITS-1:0] dir_y,
  input  logic [COMPONENT_BITS-1:0] dir_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output face_t                     out_face,
  output logic [COMPONENT_BITS:0]   out_den,
  output logic [COMPONENT_BITS:0]   out_rs,
  output logic [COMPONENT_BITS:0]   out_rt,
  output logic                      out_qs,
  output logic                      out_qt
);

  localparam int CB = COMPONENT_BITS;

  // Sign and magnitude of each component
  logic          x_neg, y_neg, z_neg;
  logic [CB-1:0] x_mag, y_mag, z_mag;
  logic          x_win, y_win, z_win;

  // Selected face and coordinates
  face_t         face_next;
  logic          sc_neg_next, tc_neg_next;
  logic [CB-1:0] sc_mag_next, tc_mag_next, ma_next;

  // Stage A registers
  logic          a_valid;
  logic          a_ready;
  face_t         a_face;
  logic          a_sc_neg, a_tc_neg;
  logic [CB-1:0] a_sc_mag, a_tc_mag, a_ma;

  // Stage B next values
  logic [CB:0]   num_s, num_t, den_next;
  logic          qs_next, qt_next;
  logic [CB:0]   rs_next, rt_next;

  // Convert components to sign and magnitude; the most negative value keeps its exact size
  always_comb begin
    x_neg = dir_x[CB-1];
    y_neg = dir_y[CB-1];
    z_neg = dir_z[CB-1];
    x_mag = x_neg ? CB'(~dir_x + 1'b1) : dir_x;
    y_mag = y_neg ? CB'(~dir_y + 1'b1) : dir_y;
    z_mag = z_neg ? CB'(~dir_z + 1'b1) : dir_z;
  end

  // Pick the major axis; on ties z beats y and y beats x
  always_comb begin
    x_win = (x_mag >= y_mag) && (x_mag >= z_mag);
    y_win = (y_mag >= x_mag) && (y_mag >= z_mag);
    z_win = (z_mag >= x_mag) && (z_mag >= y_mag);

    face_next   = FACE_POS_X;
    sc_neg_next = x_neg;
    sc_mag_next = x_mag;
    tc_neg_next = y_neg;
    tc_mag_next = y_mag;
    ma_next     = '0;

    if (z_win) begin
      // zero counts as negative, so a zero vector lands on the -z face
      face_next   = (!z_neg && z_mag != '0) ? FACE_POS_Z : FACE_NEG_Z;
      sc_neg_next = (!z_neg && z_mag != '0) ? x_neg : !x_neg;
      sc_mag_next = x_mag;
      tc_neg_next = y_neg;
      tc_mag_next = y_mag;
      ma_next     = z_mag;
    end else if (y_win) begin
      face_next   = (!y_neg && y_mag != '0) ? FACE_POS_Y : FACE_NEG_Y;
      sc_neg_next = x_neg;
      sc_mag_next = x_mag;
      tc_neg_next = (!y_neg && y_mag != '0) ? !z_neg : z_neg;
      tc_mag_next = z_mag;
      ma_next     = y_mag;
    end else if (x_win) begin
      face_next   = (!x_neg && x_mag != '0) ? FACE_POS_X : FACE_NEG_X;
      sc_neg_next = (!x_neg && x_mag != '0) ? !z_neg : z_neg;
      sc_mag_next = z_mag;
      tc_neg_next = y_neg;
      tc_mag_next = y_mag;
      ma_next     = x_mag;
    end
  end

  // Stage A handshake
  assign a_ready  = !out_valid || out_ready;
  assign in_ready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_face   <= face_next;
      a_sc_neg <= sc_neg_next;
      a_sc_mag <= sc_mag_next;
      a_tc_neg <= tc_neg_next;
      a_tc_mag <= tc_mag_next;
      a_ma     <= ma_next;
    end
  end

  // Form numerators ma +/- c and divisor 2*ma, then the integer quotient bit
  always_comb begin
    num_s    = a_sc_neg ? ({1'b0, a_ma} - {1'b0, a_sc_mag}) : ({1'b0, a_ma} + {1'b0, a_sc_mag});
    num_t    = a_tc_neg ? ({1'b0, a_ma} - {1'b0, a_tc_mag}) : ({1'b0, a_ma} + {1'b0, a_tc_mag});
    // a zero vector has zero numerators; a nonzero divisor makes its quotient zero
    den_next = (a_ma == '0) ? (CB+1)'(2) : {a_ma, 1'b0};
    qs_next  = num_s >= den_next;
    qt_next  = num_t >= den_next;
    rs_next  = qs_next ? (num_s - den_next) : num_s;
    rt_next  = qt_next ? (num_t - den_next) : num_t;
  end

  // Stage B registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_ready) begin
      out_face <= a_face;
      out_den  <= den_next;
      out_rs   <= rs_next;
      out_rt   <= rt_next;
      out_qs   <= qs_next;
      out_qt   <= qt_next;
    end
  end

endmodule

// ----- rtl/core/cmfs_div_cell.sv -----
// One restoring division cell: produces one fraction bit of s and of t per transaction.
module cmfs_div_cell
  import cmfs_pkg::*;
#(
  parameter int COMPONENT_BITS = CMFS_COMPONENT_BITS,
  parameter int FRACTION_BITS  = CMFS_FRACTION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  face_t                    in_face,
  input  logic [COMPONENT_BITS:0]  in_den,
  input  logic [COMPONENT_BITS:0]  in_rs,
  input  logic [COMPONENT_BITS:0]  in_rt,
  input  logic [FRACTION_BITS:0]   in_qs,
  input  logic [FRACTION_BITS:0]   in_qt,
  output logic                     out_valid,
  input  logic                     out_ready,
  output face_t                    out_face,
  output logic [COMPONENT_BITS:0]  out_den,
  output logic [COMPONENT_BITS:0]  out_rs,
  output logic [COMPONENT_BITS:0]  out_rt,
  output logic [FRACTION_BITS:0]   out_qs,
  output logic [FRACTION_BITS:0]   out_qt
);

  localparam int CB = COMPONENT_BITS;
  localparam int FB = FRACTION_BITS;

  logic [CB+1:0] rs_shift, rt_shift, den_ext;
  logic          ge_s, ge_t;
  logic [CB:0]   rs_next, rt_next;
  logic [FB:0]   qs_next, qt_next;

  // Shift the remainder, compare against the divisor, subtract when it fits
  always_comb begin
    den_ext  = {1'b0, in_den};
    rs_shift = {in_rs, 1'b0};
    rt_shift = {in_rt, 1'b0};
    ge_s     = rs_shift >= den_ext;
    ge_t     = rt_shift >= den_ext;
    rs_next  = ge_s ? (CB+1)'(rs_shift - den_ext) : rs_shift[CB:0];
    rt_next  = ge_t ? (CB+1)'(rt_shift - den_ext) : rt_shift[CB:0];
    qs_next  = {in_qs[FB-1:0], ge_s};
    qt_next  = {in_qt[FB-1:0], ge_t};
  end

  // Advance whenever the neighbor downstream can take the transaction
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_face <= in_face;
      out_den  <= in_den;
      out_rs   <= rs_next;
      out_rt   <= rt_next;
      out_qs   <= qs_next;
      out_qt   <= qt_next;
    end
  end

endmodule
